// ===== hw/rtl/signed_radix_digit_emitter_defines.svh =====
// Assertion macros shared by the signed radix digit emitter RTL.
// Users need signals named clk and rst_n in scope; no other dependencies.
`ifndef SIGNED_RADIX_DIGIT_EMITTER_DEFINES_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SRE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sre assertion failed");

// next-cycle implication
`define SRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sre assertion failed");

`else

`define SRE_ASSERT_IMPL(label, ante, cons)
`define SRE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/sre_pkg.sv =====
// Package for the signed radix digit emitter: sizes, codes, types, helpers.
// No dependencies.
package sre_pkg;

    // input and register sizes
    localparam int VALUE_WIDTH = 64;
    localparam int MAX_RADIX   = 20;
    localparam int MIN_RADIX   = 2;
    localparam int RADIX_W     = 5;
    localparam int SYM_W       = 7;
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    // magnitude and digit stack
    localparam int MAG_W       = VALUE_WIDTH - 1;
    localparam int STACK_DEPTH = MAG_W;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DIGIT_W     = 5;

    // long division: DIGIT_BITS dividend bits per cycle
    localparam int DIGIT_BITS  = 8;
    localparam int DIV_W       = ((MAG_W + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS;
    localparam int DIV_STEPS   = DIV_W / DIGIT_BITS;
    localparam int STEP_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // front-to-back queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // ASCII codes
    localparam logic [SYM_W-1:0] ASCII_MINUS  = SYM_W'(45);
    localparam logic [SYM_W-1:0] ASCII_ZERO   = SYM_W'(48);
    localparam logic [SYM_W-1:0] ASCII_ALPHA  = SYM_W'(55);  // 'A' - 10
    localparam logic [SYM_W-1:0] SYM_NONE     = SYM_W'(0);
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

    // one classified word from front to back
    typedef struct packed {
        logic                   bad;
        logic                   neg;
        logic [MAG_W-1:0]       mag;
        logic [RADIX_W-1:0]     radix;
    } sre_item_t;

    // back-end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SIGN,
        BK_READ,
        BK_EMIT,
        BK_BAD
    } sre_bk_state_t;

    // digit value to ASCII character
    function automatic logic [SYM_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [SYM_W-1:0] ext;
        ext = SYM_W'(d);
        if (d < DEC_DIGITS)
            return ASCII_ZERO + ext;
        return ASCII_ALPHA + ext;
    endfunction

endpackage

// ===== hw/rtl/sre_front.sv =====
// Front end: holds the radix register, accepts input words, classifies them.
// Depends on sre_pkg.
module sre_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 radix_we,
    input  logic [4:0]           radix_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [63:0]          value,
    input  logic                 q_full,
    output logic                 q_push,
    output sre_pkg::sre_item_t   q_item
);
    import sre_pkg::*;

    logic [RADIX_W-1:0]     radix_reg;
    logic [VALUE_WIDTH-1:0] v;
    logic [VALUE_WIDTH-1:0] v_neg;
    logic                   neg;
    logic                   bad;

    // radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (radix_we)
            radix_reg <= radix_wdata;
    end

    // classify: range check, sign, saturated magnitude
    always_comb
    begin
        v     = value[VALUE_WIDTH-1:0];
        neg   = v[VALUE_WIDTH-1];
        v_neg = ~v + VALUE_WIDTH'(1);
        bad   = (int'(radix_reg) < MIN_RADIX) || (int'(radix_reg) > MAX_RADIX);

        q_item.bad   = bad;
        q_item.neg   = neg;
        q_item.radix = radix_reg;
        if (!neg)
            q_item.mag = v[MAG_W-1:0];
        else if (v_neg[VALUE_WIDTH-1])
            q_item.mag = {MAG_W{1'b1}};   // most negative value saturates
        else
            q_item.mag = v_neg[MAG_W-1:0];
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

endmodule

// ===== hw/rtl/sre_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on sre_pkg and the assertion macro header.
`include "signed_radix_digit_emitter_defines.svh"

module sre_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sre_pkg::sre_item_t   push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output sre_pkg::sre_item_t   pop_item
);
    import sre_pkg::*;

    sre_item_t          entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - Q_CNT_W'(1);
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    `SRE_ASSERT_IMPL(a_no_overflow, push, count_reg != Q_CNT_W'(Q_DEPTH))
    `SRE_ASSERT_IMPL(a_no_underflow, pop, count_reg != '0)
    `SRE_ASSERT_NEXT(a_count_grows, push && !pop, count_reg == Q_CNT_W'($past(count_reg) + 2'd1))

endmodule

// ===== hw/rtl/sre_back.sv =====
// Back end: long division into a digit stack, then sign and digits out MSD first, or one bad-radix word.
// Depends on sre_pkg and the assertion macro header.
`include "signed_radix_digit_emitter_defines.svh"

module sre_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  sre_pkg::sre_item_t   q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [6:0]           symbol,
    output logic                 last,
    output logic                 bad_radix
);
    import sre_pkg::*;

    sre_bk_state_t        state_reg;
    sre_bk_state_t        state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [DIV_W-1:0]     work_reg;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [RADIX_W-1:0]   radix_reg;
    logic                 neg_reg;
    logic [DIGIT_W-1:0]   rd_reg;
    logic [DIGIT_W-1:0]   stack_mem [STACK_DEPTH];

    logic                 out_valid_reg;
    logic [SYM_W-1:0]     out_sym_reg;
    logic                 out_last_reg;
    logic                 out_bad_reg;

    logic [DIV_W-1:0]     w_next;
    logic [DIGIT_W:0]     r_next;
    logic                 digit_end;
    logic                 quot_zero;
    logic                 out_free;
    logic                 out_load;
    logic [SYM_W-1:0]     sym_next;
    logic                 last_next;
    logic                 bad_next;

    // one slice of restoring division: DIGIT_BITS quotient bits per cycle
    always_comb
    begin
        w_next = work_reg;
        r_next = {1'b0, rem_reg};
        for (int i = 0; i < DIGIT_BITS; i++)
        begin
            r_next = {r_next[DIGIT_W-1:0], w_next[DIV_W-1]};
            w_next = {w_next[DIV_W-2:0], 1'b0};
            if (r_next >= {1'b0, radix_reg})
            begin
                r_next    = r_next - {1'b0, radix_reg};
                w_next[0] = 1'b1;
            end
        end
    end

    assign digit_end = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign quot_zero = (w_next == '0);
    assign out_free  = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (q_valid)
                    state_next = q_item.bad ? BK_BAD : BK_DIV;
            BK_DIV:
                if (digit_end && quot_zero)
                    state_next = neg_reg ? BK_SIGN : BK_READ;
            BK_SIGN:
                if (out_free)
                    state_next = BK_READ;
            BK_READ:
                state_next = BK_EMIT;
            BK_EMIT:
                if (out_free)
                    state_next = (cnt_reg == '0) ? BK_IDLE : BK_READ;
            BK_BAD:
                if (out_free)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop     = 1'b0;
        out_load  = 1'b0;
        sym_next  = SYM_NONE;
        last_next = 1'b0;
        bad_next  = 1'b0;
        unique case (state_reg)
            BK_IDLE:
                q_pop = q_valid;
            BK_SIGN:
            begin
                out_load = out_free;
                sym_next = ASCII_MINUS;
            end
            BK_EMIT:
            begin
                out_load  = out_free;
                sym_next  = digit_char(rd_reg);
                last_next = (cnt_reg == '0);
            end
            BK_BAD:
            begin
                out_load  = out_free;
                last_next = 1'b1;
                bad_next  = 1'b1;
            end
            BK_DIV, BK_READ:
                q_pop = 1'b0;
            default:
                q_pop = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                cnt_reg  <= '0;
                step_reg <= '0;
            end
            else if (state_reg == BK_DIV)
            begin
                step_reg <= digit_end ? '0 : step_reg + STEP_W'(1);
                if (digit_end)
                    cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (state_reg == BK_READ)
                cnt_reg <= cnt_reg - CNT_W'(1);

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            work_reg  <= DIV_W'(q_item.mag);
            rem_reg   <= '0;
            radix_reg <= q_item.radix;
            neg_reg   <= q_item.neg;
        end
        else if (state_reg == BK_DIV)
        begin
            work_reg <= w_next;
            rem_reg  <= digit_end ? '0 : r_next[DIGIT_W-1:0];
        end

        if (out_load)
        begin
            out_sym_reg  <= sym_next;
            out_last_reg <= last_next;
            out_bad_reg  <= bad_next;
        end
    end

    // digit stack: push during division, pop while emitting
    always_ff @(posedge clk)
    begin
        if ((state_reg == BK_DIV) && digit_end)
            stack_mem[cnt_reg[ADDR_W-1:0]] <= r_next[DIGIT_W-1:0];
        if (state_reg == BK_READ)
            rd_reg <= stack_mem[ADDR_W'(cnt_reg - CNT_W'(1))];
    end

    assign out_valid = out_valid_reg;
    assign symbol    = out_sym_reg;
    assign last      = out_last_reg;
    assign bad_radix = out_bad_reg;

    `SRE_ASSERT_IMPL(a_rem_below_radix, state_reg == BK_DIV, rem_reg < radix_reg)
    `SRE_ASSERT_IMPL(a_cnt_in_range, 1'b1, cnt_reg <= CNT_W'(STACK_DEPTH))
    `SRE_ASSERT_NEXT(a_sign_word, (state_reg == BK_SIGN) && out_free, out_valid_reg && !out_last_reg && (out_sym_reg == ASCII_MINUS))

endmodule

// ===== hw/rtl/signed_radix_digit_emitter.sv =====
// Signed radix digit emitter: each value is dequeued and divided digit by digit (8 dividend
// bits per cycle) into a digit stack; then a sign for a negative value and the digits go out MSD first.
// The back end converts one value at a time; a two-word queue takes the next value meanwhile.
// Reset (rst_n, async, active low) sets radix to 10 and empties queue and output.
module signed_radix_digit_emitter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        radix_we,
    input  logic [4:0]  radix_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  symbol,
    output logic        last,
    output logic        bad_radix
);
    import sre_pkg::*;

    sre_item_t push_item;
    sre_item_t pop_item;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;

    // accept and classify
    sre_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    // decoupling queue
    sre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (pop_item)
    );

    // divide and emit
    sre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .symbol    (symbol),
        .last      (last),
        .bad_radix (bad_radix)
    );

endmodule

// ===== test/sre_checker.sv =====
// Checker for the signed radix digit emitter: tracks the radix register,
// expands every accepted value into its expected symbol words and compares.
// Depends on sre_pkg for sizes and codes.
module sre_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        radix_we,
    input  logic [4:0]  radix_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [63:0] value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [6:0]  symbol,
    input  logic        last,
    input  logic        bad_radix,
    output int          errors,
    output int          pending
);
    import sre_pkg::*;

    localparam logic [SYM_W-1:0] CHAR_ZERO = SYM_W'("0");
    localparam logic [SYM_W-1:0] CHAR_A    = SYM_W'("A");

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             bad;
    } sym_word_t;

    sym_word_t            symbols_due[$];
    logic [RADIX_W-1:0]   radix_now;
    int                   fail_count;

    // add one expected word at the tail
    function automatic void append_word(input sym_word_t w);
        symbols_due = {symbols_due, w};
    endfunction

    // expected symbol words for one value in the given base
    function automatic void expand_value(input logic [VALUE_WIDTH-1:0] v,
                                         input logic [RADIX_W-1:0] r);
        logic [VALUE_WIDTH-1:0] mag;
        logic [DIGIT_W-1:0]     digits[$];
        logic [DIGIT_W-1:0]     d;
        logic                   neg;
        sym_word_t              w;
        int                     i;
        if (r < MIN_RADIX || r > MAX_RADIX)
        begin
            w.symbol = '0;
            w.last   = 1'b1;
            w.bad    = 1'b1;
            append_word(w);
            return;
        end
        neg = v[VALUE_WIDTH-1];
        mag = neg ? -v : v;
        // most negative input: magnitude clamps to the largest positive one
        if (mag[VALUE_WIDTH-1])
            mag = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        do
        begin
            digits = {digits, DIGIT_W'(mag % r)};
            mag = mag / r;
        end
        while (mag != 0);
        w.bad = 1'b0;
        if (neg)
        begin
            w.symbol = ASCII_MINUS;
            w.last   = 1'b0;
            append_word(w);
        end
        for (i = digits.size() - 1; i >= 0; i--)
        begin
            d        = digits[i];
            w.symbol = (d < 10) ? CHAR_ZERO + SYM_W'(d) : CHAR_A + SYM_W'(d - 10);
            w.last   = (i == 0);
            append_word(w);
        end
    endfunction

    function automatic void note_fail();
        fail_count++;
    endfunction

    // watch register writes, accepted values and accepted symbol words
    always @(posedge clk)
    begin
        sym_word_t w;
        if (!rst_n)
        begin
            radix_now = RADIX_RESET;
        end
        else
        begin
            if (radix_we)
                radix_now = radix_wdata;
            if (in_valid && !in_stall)
                expand_value(value, radix_now);
            if (out_valid && !out_stall)
            begin
                if (symbols_due.size() == 0)
                begin
                    note_fail();
                    $display("%0t: expected no word, actual symbol %h last %b bad_radix %b",
                             $time, symbol, last, bad_radix);
                end
                else
                begin
                    w = symbols_due.pop_front();
                    if (symbol !== w.symbol)
                    begin
                        note_fail();
                        $display("%0t: symbol expected %h actual %h",
                                 $time, w.symbol, symbol);
                    end
                    if (last !== w.last)
                    begin
                        note_fail();
                        $display("%0t: last expected %b actual %b", $time, w.last, last);
                    end
                    if (bad_radix !== w.bad)
                    begin
                        note_fail();
                        $display("%0t: bad_radix expected %b actual %b",
                                 $time, w.bad, bad_radix);
                    end
                end
            end
        end
        pending <= symbols_due.size();
        errors  <= fail_count;
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the signed radix digit emitter testbench: clock, reset, value
// stimulus, random output stalls and the verdict. Depends on sre_pkg,
// sre_checker and the block itself.
module tb_top;
    import sre_pkg::*;

    localparam int          RANDOM_ITEMS = 387;
    localparam int          CYCLE_LIMIT  = 4_000_000;
    localparam int          SETTLE       = 40;
    localparam logic [63:0] POS_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAX      = 64'h8000_0000_0000_0001;
    localparam logic [63:0] NEG_EXTREME  = 64'h8000_0000_0000_0000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        radix_we    = 1'b0;
    logic [4:0]  radix_wdata = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [63:0] value       = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [6:0]  symbol;
    logic        last;
    logic        bad_radix;

    int          errors;
    int          pending;
    int          cycles      = 0;
    logic        no_gaps     = 1'b0;
    logic [4:0]  radix_cur   = RADIX_RESET;

    signed_radix_digit_emitter u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .symbol      (symbol),
        .last        (last),
        .bad_radix   (bad_radix)
    );

    sre_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .symbol      (symbol),
        .last        (last),
        .bad_radix   (bad_radix),
        .errors      (errors),
        .pending     (pending)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // run guard
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // receiver stalls: mostly short bursts, sometimes long, sometimes long free runs
    initial
    begin
        int n;
        forever
        begin
            n = $urandom_range(0, 99);
            if (n < 50)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else if (n < 85)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else if (n < 95)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(8, 25)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(30, 80)) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int n;
        n = $urandom_range(0, 99);
        if (no_gaps || n < 60)
            return 0;
        if (n < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // value mix: full width, small, negative small, random length, edges
    function automatic logic [63:0] pick_value(input logic [4:0] r);
        logic [63:0] v;
        int          kind;
        kind = $urandom_range(0, 9);
        v    = {$urandom, $urandom};
        case (kind)
            0, 1, 2: ;
            3, 4, 5: v = 64'($urandom_range(0, 400));
            6:       v = -64'($urandom_range(1, 400));
            7, 8:
            begin
                v = v >> $urandom_range(1, 63);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default:
            begin
                case ($urandom_range(0, 7))
                    0: v = POS_MAX;
                    1: v = NEG_MAX;
                    2: v = '0;
                    3: v = '1;
                    4: v = 64'(r) - 1;
                    5: v = 64'(r);
                    6: v = 64'(r) * 64'(r);
                    default: v = -64'(r);
                endcase
            end
        endcase
        return v;
    endfunction

    // hand one word to the block, then idle for a random gap, which may be zero
    task automatic push_value(input logic [63:0] v);
        int gap;
        value    <= v;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every symbol is out, then write the radix
    task automatic set_radix(input logic [4:0] r);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
        radix_we    <= 1'b1;
        radix_wdata <= r;
        @(posedge clk);
        radix_we    <= 1'b0;
        radix_cur    = r;
    endtask

    function automatic logic [4:0] pick_radix();
        int n;
        n = $urandom_range(0, 99);
        if (n < 8)
            return 5'($urandom_range(0, 1));
        if (n < 15)
            return 5'($urandom_range(21, 31));
        if (n < 30)
            return 5'd2;
        if (n < 45)
            return 5'd20;
        return 5'($urandom_range(2, 20));
    endfunction

    initial
    begin
        int sent;
        int count;
        int i;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // base 10 from reset: zero, small, signs, extremes, clamped minimum
        push_value(64'd0);
        push_value(64'd1);
        push_value('1);
        push_value(64'd9);
        push_value(64'd10);
        push_value(POS_MAX);
        push_value(NEG_MAX);
        push_value(NEG_EXTREME);
        push_value(-64'd987654321);

        // base 2: longest digit strings
        set_radix(5'd2);
        push_value(POS_MAX);
        push_value('1);
        push_value(64'd0);
        push_value(64'd5);

        // base 20: letter digits up to J
        set_radix(5'd20);
        push_value(POS_MAX);
        push_value(NEG_MAX);
        push_value(64'd19);
        push_value(64'd20);
        push_value(64'd399);

        // bases out of range
        set_radix(5'd0);
        push_value(64'd7);
        set_radix(5'd1);
        push_value(-64'd3);
        set_radix(5'd21);
        push_value(64'd0);
        set_radix(5'd31);
        push_value(POS_MAX);

        set_radix(5'd16);
        push_value(64'd255);

        // random phases, each with its own base
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_radix(pick_radix());
            no_gaps = ($urandom_range(0, 3) == 0);
            count   = $urandom_range(15, 45);
            for (i = 0; i < count; i++)
                push_value(pick_value(radix_cur));
            sent += count;
        end

        // drain
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
